/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/sqe_pkg.sv */
package sqe_pkg;

    // Width of one stored element.
    localparam int DATA_W = 32;

    // Operation codes carried by each input item.
    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_DUMP = 2'd1,
        FUNC_PEEK = 2'd2,
        FUNC_POP  = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_HOLD      = 3'd0,
        CMD_PUSH_TOP  = 3'd1,
        CMD_PUSH_TAIL = 3'd2,
        CMD_POP       = 3'd3,
        CMD_ROTATE    = 3'd4
    } cell_cmd_t;

    // Control group handed from the sequencer to the cell chain.
    typedef struct packed {
        cell_cmd_t cmd;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic {
        S_ACCEPT = 1'b0,
        S_DUMP   = 1'b1
    } state_t;

endpackage

/* sv/sqe_cell.sv */
module sqe_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                      clk,
    input  sqe_pkg::cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic [CNT_W-1:0]          tail,
    input  logic [sqe_pkg::DATA_W-1:0] upper_data,
    input  logic [sqe_pkg::DATA_W-1:0] lower_data,
    input  logic [sqe_pkg::DATA_W-1:0] ext_data,
    input  logic [sqe_pkg::DATA_W-1:0] head_data,
    output logic [sqe_pkg::DATA_W-1:0] data
);

    logic [sqe_pkg::DATA_W-1:0] data_reg;
    logic [sqe_pkg::DATA_W-1:0] data_next;
    logic                       at_count;
    logic                       at_tail;

    assign at_count = (count == CNT_W'(INDEX));
    assign at_tail  = (tail == CNT_W'(INDEX));

    // Choose between holding, a neighbour's element, the pushed value and the head.
    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            sqe_pkg::CMD_HOLD:      data_next = data_reg;
            sqe_pkg::CMD_PUSH_TOP:  data_next = upper_data;
            sqe_pkg::CMD_PUSH_TAIL: data_next = at_count ? ext_data : data_reg;
            sqe_pkg::CMD_POP:       data_next = lower_data;
            sqe_pkg::CMD_ROTATE:    data_next = at_tail ? head_data : lower_data;
            default:                data_next = data_reg;
        endcase
    end

    // Element register; its contents only matter while it is live.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* sv/stack_queue_engine.sv */
// Bounded store of signed 32-bit integers that works as a stack, or as a
// queue when queue_mode is set through cfg_wr_en / cfg_wr_data.
// Input channel: in_valid, in_stall, func, push_value. Output channel:
// out_valid, out_stall, read_value, has_value, status, last. A transfer
// happens on a rising edge with valid high and stall low.
// The elements sit in a chain of DEPTH cells, top at the first cell; stack push,
// pop and dump shift the chain by one place; a queue push writes behind the tail.
// Push, pop and peek load their result into the output register in the cycle
// after the transfer, and a new item may follow at once.
// Dump first enters the dump state, then gives one element per cycle while the
// output is not stalled, the chain rotating one place each time; an empty
// dump gives no result. The input is stalled while a dump is running.
// When the receiver stalls, the output register holds its result and the
// input is stalled until that result is taken.
// Reset empties the store and clears queue_mode; it needs no clearing pass.
// queue_mode is to be written only while the block is idle.
module stack_queue_engine #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] push_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_value,
    output logic        has_value,
    output logic [1:0]  status,
    output logic        last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    sqe_pkg::state_t            state_reg;
    sqe_pkg::state_t            state_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           remain_reg;
    logic [CNT_W-1:0]           remain_next;
    logic [CNT_W-1:0]           tail;
    logic                       queue_mode_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [sqe_pkg::DATA_W-1:0] value_reg;
    logic [sqe_pkg::DATA_W-1:0] value_next;
    logic                       has_reg;
    logic                       has_next;
    sqe_pkg::status_t           status_reg;
    sqe_pkg::status_t           status_next;
    logic                       last_reg;
    logic                       last_next;

    logic                       out_free;
    logic                       accept;
    logic                       load_out;
    sqe_pkg::cell_ctrl_t        ctrl;
    sqe_pkg::func_t             op;

    logic [sqe_pkg::DATA_W-1:0] cell_data [DEPTH];

    assign op       = sqe_pkg::func_t'(func);
    assign tail     = count_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != sqe_pkg::S_ACCEPT) || !out_free;
    assign accept   = in_valid && !in_stall;

    // Sequencer: decodes each item and steps the dump through the chain.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        ctrl.cmd    = sqe_pkg::CMD_HOLD;
        load_out    = 1'b0;
        value_next  = '0;
        has_next    = 1'b0;
        status_next = sqe_pkg::ST_OK;
        last_next   = 1'b1;
        unique case (state_reg)
            sqe_pkg::S_ACCEPT:
            begin
                if (accept)
                begin
                    unique case (op)
                        sqe_pkg::FUNC_PUSH:
                        begin
                            load_out = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = sqe_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                ctrl.cmd   = queue_mode_reg ? sqe_pkg::CMD_PUSH_TAIL
                                                            : sqe_pkg::CMD_PUSH_TOP;
                            end
                        end
                        sqe_pkg::FUNC_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next  = sqe_pkg::S_DUMP;
                                remain_next = count_reg;
                            end
                        end
                        sqe_pkg::FUNC_PEEK:
                        begin
                            load_out = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = sqe_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                value_next = cell_data[0];
                                has_next   = 1'b1;
                            end
                        end
                        sqe_pkg::FUNC_POP:
                        begin
                            load_out = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = sqe_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                ctrl.cmd   = sqe_pkg::CMD_POP;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            sqe_pkg::S_DUMP:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    value_next  = cell_data[0];
                    has_next    = 1'b1;
                    last_next   = (remain_reg == CNT_W'(1));
                    ctrl.cmd    = sqe_pkg::CMD_ROTATE;
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = sqe_pkg::S_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = sqe_pkg::S_ACCEPT;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sqe_pkg::S_ACCEPT;
            count_reg      <= '0;
            remain_reg     <= '0;
            queue_mode_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                queue_mode_reg <= cfg_wr_data;
            end
        end
    end

    // Output payload register, loaded on each new result.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_reg  <= value_next;
            has_reg    <= has_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    // Chain of element cells, top first.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [sqe_pkg::DATA_W-1:0] upper;
        logic [sqe_pkg::DATA_W-1:0] lower;

        if (i == 0)
        begin : g_first
            assign upper = push_value;
        end
        else
        begin : g_mid_up
            assign upper = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_final
            assign lower = cell_data[i];
        end
        else
        begin : g_mid_low
            assign lower = cell_data[i+1];
        end

        sqe_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .tail       (tail),
            .upper_data (upper),
            .lower_data (lower),
            .ext_data   (push_value),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign out_valid  = out_valid_reg;
    assign read_value = value_reg;
    assign has_value  = has_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

/* sv/sqe_checker.sv */
`include "assert_macros.svh"

module sqe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] read_value,
    input logic        has_value,
    input logic [1:0]  status,
    input logic        last
);

    // A stalled result stays offered and unchanged.
    `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(last), "stalled result changed")

    // Only successful reads carry an element.
    `ASSERT_CLK_RST(a_has_ok, clk, rst_n, out_valid && has_value |-> status == sqe_pkg::ST_OK, "element carried with an error status")

    // A result that is not the final one of its item can only come from a dump.
    `ASSERT_CLK_RST(a_not_last_dump, clk, rst_n, out_valid && !last |-> has_value, "non-final result without an element")

    // Results without an element read as zero and carry a defined status.
    `ASSERT_CLK_RST(a_zero_value, clk, rst_n, out_valid && !has_value |-> read_value == 32'd0 && (status == sqe_pkg::ST_OK || status == sqe_pkg::ST_EMPTY || status == sqe_pkg::ST_FULL), "bad result without an element")

    // No result is offered while reset is held.
    `ASSERT_CLK(a_reset_quiet, clk, !rst_n |-> !out_valid, "result offered during reset")

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .has_value  (has_value),
    .status     (status),
    .last       (last)
);
